// ===== design/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the max-heap priority queue core.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam logic ACT_INSERT  = 1'b0;
	localparam logic ACT_EXTRACT = 1'b1;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_EMPTY_EXTR = 2'd1;
	localparam logic [1:0] STAT_FULL_DROP  = 2'd2;

	// fixed port width of every key field
	localparam int unsigned PORT_KEY_W = 32;

	typedef struct packed {
		logic ins;
		logic ext;
	} cell_cmd_t;

endpackage

// ===== design/mhpq_cell.sv =====
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted key chain. Keys stay in descending order from the
// head; an insert shifts smaller keys one slot toward the tail, an extract
// shifts every key one slot toward the head.
// ----------------------------------------------------------------------------
module mhpq_cell #(
	parameter int unsigned KEY_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mhpq_pkg::cell_cmd_t         cmd,
	input  logic signed [KEY_WIDTH-1:0] new_key,
	input  logic                        left_valid,
	input  logic signed [KEY_WIDTH-1:0] left_key,
	input  logic                        right_valid,
	input  logic signed [KEY_WIDTH-1:0] right_key,
	output logic                        valid,
	output logic signed [KEY_WIDTH-1:0] key
);

	logic                        valid_q;
	logic signed [KEY_WIDTH-1:0] key_q;
	logic                        displaced;

	assign displaced = !valid_q || (new_key > key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ext) begin
			valid_q <= right_valid;
		end else if (cmd.ins && displaced) begin
			valid_q <= left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ext) begin
			key_q <= right_key;
		end else if (cmd.ins && displaced) begin
			if (left_valid && (left_key >= new_key)) begin
				key_q <= new_key;
			end else begin
				key_q <= left_key;
			end
		end
	end

	assign valid = valid_q;
	assign key   = key_q;

endmodule

// ===== design/max_heap_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// Max priority queue of signed keys: insert and extract-max requests, one
// status result per request.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser is the action (0 insert, 1 extract maximum),
// s_tdata carries key_in. Output channel m_*: one result per request with
// status, extracted key, current maximum, entry count and empty flag.
// Keys sit in a chain of CAPACITY cells kept in descending order; every cell
// compares the broadcast key with its own and shifts on acceptance, and a
// result is registered on m_* the cycle after acceptance. Throughput is one
// request per cycle while m_* is not stalled, set by the cell update.
// The output register parts the two sides: s_tready stays high while the
// result register is empty or being taken, and drops while m_tvalid waits on
// a low m_tready. Reset empties the queue and clears m_tvalid; no clearing
// pass is needed since every cell has its own valid flag.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_core #(
	parameter int unsigned CAPACITY  = 64,
	parameter int unsigned KEY_WIDTH = 32,
	localparam int unsigned CNT_W    = $clog2(CAPACITY + 1),
	localparam int unsigned OUT_RAW  = 3 + 2 * mhpq_pkg::PORT_KEY_W + CNT_W,
	localparam int unsigned OUT_W    = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,  // [31:0] key_in
	input  logic             s_tuser,  // [0] action
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // status, extracted_key, top_key,
	                                   // entry_count, heap_empty, zero pad
);

	logic signed [KEY_WIDTH-1:0] new_key;
	logic                        accept;
	logic                        is_full;
	logic                        is_empty;
	mhpq_pkg::cell_cmd_t         cmd;

	logic                        cell_valid [CAPACITY];
	logic signed [KEY_WIDTH-1:0] cell_key   [CAPACITY];

	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            count_nx;
	logic [1:0]                  status;
	logic signed [KEY_WIDTH-1:0] extr_key;
	logic signed [KEY_WIDTH-1:0] top_key;

	logic                        m_tvalid_q;
	logic [OUT_W-1:0]            m_tdata_q;

	assign new_key  = KEY_WIDTH'($signed(s_tdata));
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	assign cmd.ins = accept && (s_tuser == mhpq_pkg::ACT_INSERT) && !is_full;
	assign cmd.ext = accept && (s_tuser == mhpq_pkg::ACT_EXTRACT) && !is_empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                        lv;
		logic signed [KEY_WIDTH-1:0] lk;
		logic                        rv;
		logic signed [KEY_WIDTH-1:0] rk;

		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign lk = new_key;
		end else begin : g_body
			assign lv = cell_valid[i-1];
			assign lk = cell_key[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign rv = 1'b0;
			assign rk = '0;
		end else begin : g_inner
			assign rv = cell_valid[i+1];
			assign rk = cell_key[i+1];
		end

		mhpq_cell #(
			.KEY_WIDTH (KEY_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.new_key     (new_key),
			.left_valid  (lv),
			.left_key    (lk),
			.right_valid (rv),
			.right_key   (rk),
			.valid       (cell_valid[i]),
			.key         (cell_key[i])
		);
	end

	always_comb begin
		status   = mhpq_pkg::STAT_OK;
		extr_key = '0;
		count_nx = count_q;
		top_key  = is_empty ? '0 : cell_key[0];
		if (s_tuser == mhpq_pkg::ACT_INSERT) begin
			if (is_full) begin
				status = mhpq_pkg::STAT_FULL_DROP;
			end else begin
				count_nx = count_q + 1'b1;
				if (is_empty || (new_key > cell_key[0])) begin
					top_key = new_key;
				end
			end
		end else begin
			if (is_empty) begin
				status = mhpq_pkg::STAT_EMPTY_EXTR;
			end else begin
				extr_key = cell_key[0];
				count_nx = count_q - 1'b1;
				top_key  = (count_q > CNT_W'(1)) ? cell_key[1] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_nx;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= OUT_W'({(count_nx == '0), count_nx,
				mhpq_pkg::PORT_KEY_W'(top_key),
				mhpq_pkg::PORT_KEY_W'(extr_key), status});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
